// ===== rtl/core/qae_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qae_pkg
// Types, widths and arithmetic helpers for the quaternion attitude error unit.
// ----------------------------------------------------------------------------
package qae_pkg;

    localparam int FRAC_BITS = 30;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;
    localparam int RND_W     = PROD_W - FRAC_BITS;
    localparam int SUM_W     = RND_W + 2;
    localparam int COMB_W    = Q_W + 1;
    localparam int ARG_W     = Q_W + 3;
    localparam int RAD_W     = 64;
    localparam int SQT_W     = RAD_W + 2;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQ_N      = ROOT_W;
    localparam int DV_N      = RAD_W - ROOT_W;
    localparam int VAL_W     = Q_W + 2;
    localparam int N_PROD    = 10;
    localparam int N_DCM     = 9;
    localparam int N_CBR     = 27;

    typedef logic signed [Q_W-1:0]   q_t;
    typedef logic signed [RND_W-1:0] rnd_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic signed [ARG_W-1:0] arg_t;
    typedef logic signed [VAL_W-1:0] val_t;

    typedef rnd_t prod_arr_t [N_PROD];
    typedef q_t   dcm_t [N_DCM];

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } branch_t;

    typedef struct packed {
        branch_t                     br;
        logic [2:0][COMB_W-1:0]      comb;
    } sq_side_t;

    typedef struct packed {
        branch_t                     br;
        logic [ROOT_W-1:0]           piv;
        logic                        pz;
        logic [2:0]                  neg;
        logic [2:0]                  ovf;
    } dv_side_t;

    localparam int PROD_A [N_PROD] = '{0, 1, 2, 3, 0, 0, 0, 1, 1, 2};
    localparam int PROD_B [N_PROD] = '{0, 1, 2, 3, 1, 2, 3, 2, 3, 3};

    localparam arg_t ARG_ONE = arg_t'(1) <<< FRAC_BITS;

    function automatic rnd_t rmul(input q_t a, input q_t b);
        logic signed [PROD_W-1:0] p;
        p = a * b + $signed(PROD_W'(1) << (FRAC_BITS - 1));
        return p[PROD_W-1:FRAC_BITS];
    endfunction

    function automatic sum_t sx_rnd(input rnd_t v);
        return {{(SUM_W-RND_W){v[RND_W-1]}}, v};
    endfunction

    function automatic arg_t sx_arg(input q_t v);
        return {{(ARG_W-Q_W){v[Q_W-1]}}, v};
    endfunction

    function automatic q_t sat_q(input sum_t v);
        if (v[SUM_W-1:Q_W-1] == '0 || v[SUM_W-1:Q_W-1] == '1) begin
            return v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            return {1'b0, {(Q_W-1){1'b1}}};
        end
    endfunction

    function automatic dcm_t quat_dcm(input prod_arr_t m);
        dcm_t c;
        c[0] = sat_q(sx_rnd(m[0]) + sx_rnd(m[1]) - sx_rnd(m[2]) - sx_rnd(m[3]));
        c[1] = sat_q((sx_rnd(m[7]) + sx_rnd(m[6])) <<< 1);
        c[2] = sat_q((sx_rnd(m[8]) - sx_rnd(m[5])) <<< 1);
        c[3] = sat_q((sx_rnd(m[7]) - sx_rnd(m[6])) <<< 1);
        c[4] = sat_q(sx_rnd(m[0]) - sx_rnd(m[1]) + sx_rnd(m[2]) - sx_rnd(m[3]));
        c[5] = sat_q((sx_rnd(m[9]) + sx_rnd(m[4])) <<< 1);
        c[6] = sat_q((sx_rnd(m[8]) + sx_rnd(m[5])) <<< 1);
        c[7] = sat_q((sx_rnd(m[9]) - sx_rnd(m[4])) <<< 1);
        c[8] = sat_q(sx_rnd(m[0]) - sx_rnd(m[1]) - sx_rnd(m[2]) + sx_rnd(m[3]));
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/quaternion_attitude_error_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_attitude_error_unit
// Error quaternion between body and reference attitude via DCMs and
// Shepperd's method, fully pipelined.
// ----------------------------------------------------------------------------
// channel   prefix  dir  payload
// input     s_      in   body_q0..3, ref_q0..3 (Q2.30)
// result    m_      out  err_q0..3 (Q2.30)
//
// One item per cycle while the output stage is empty or its result is taken.
// The pipeline depth is set by the square root (one root bit per stage, 32 stages) and
// the pivot dividers (one quotient bit per stage, 32 stages).
// Reset clears the valid bits only. When the result is not taken the whole
// pipeline holds; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module quaternion_attitude_error_unit (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire qae_pkg::q_t   s_body_q0,
    input  wire qae_pkg::q_t   s_body_q1,
    input  wire qae_pkg::q_t   s_body_q2,
    input  wire qae_pkg::q_t   s_body_q3,
    input  wire qae_pkg::q_t   s_ref_q0,
    input  wire qae_pkg::q_t   s_ref_q1,
    input  wire qae_pkg::q_t   s_ref_q2,
    input  wire qae_pkg::q_t   s_ref_q3,
    output logic               m_valid,
    input  wire logic          m_ready,
    output qae_pkg::q_t        m_err_q0,
    output qae_pkg::q_t        m_err_q1,
    output qae_pkg::q_t        m_err_q2,
    output qae_pkg::q_t        m_err_q3
);
    import qae_pkg::*;

    logic adv;

    q_t        qb [4];
    q_t        qr [4];
    prod_arr_t s1_mb_next, s1_mr_next, s1_mb_reg, s1_mr_reg;
    logic      s1_vld_reg;
    dcm_t      s2_cb_next, s2_cr_next, s2_cb_reg, s2_cr_reg;
    logic      s2_vld_reg;
    rnd_t      s3_p_next [N_CBR];
    rnd_t      s3_p_reg  [N_CBR];
    logic      s3_vld_reg;
    q_t        s4_c_next [N_DCM];
    q_t        s4_c_reg  [N_DCM];
    logic      s4_vld_reg;

    logic [RAD_W-1:0]  sq_rem_reg  [0:SQ_N];
    logic [ROOT_W-1:0] sq_root_reg [0:SQ_N];
    sq_side_t          sq_side_reg [0:SQ_N];
    logic [SQ_N:0]     sq_vld_reg;

    logic [RAD_W-1:0]  dv_rem_reg  [0:DV_N][0:2];
    logic [DV_N-1:0]   dv_quo_reg  [0:DV_N][0:2];
    dv_side_t          dv_side_reg [0:DV_N];
    logic [DV_N:0]     dv_vld_reg;

    logic     m_valid_reg;
    q_t       m_err_reg  [4];
    q_t       m_err_next [4];

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = m_valid_reg;
    assign m_err_q0 = m_err_reg[0];
    assign m_err_q1 = m_err_reg[1];
    assign m_err_q2 = m_err_reg[2];
    assign m_err_q3 = m_err_reg[3];

    // stage 1: quaternion products
    always_comb begin
        qb[0] = s_body_q0;
        qb[1] = s_body_q1;
        qb[2] = s_body_q2;
        qb[3] = s_body_q3;
        qr[0] = s_ref_q0;
        qr[1] = s_ref_q1;
        qr[2] = s_ref_q2;
        qr[3] = s_ref_q3;
        for (int i = 0; i < N_PROD; i++) begin
            s1_mb_next[i] = rmul(qb[PROD_A[i]], qb[PROD_B[i]]);
            s1_mr_next[i] = rmul(qr[PROD_A[i]], qr[PROD_B[i]]);
        end
    end

    // stage 2: DCMs; stage 3: C_BR products; stage 4: C_BR sums
    always_comb begin
        s2_cb_next = quat_dcm(s1_mb_reg);
        s2_cr_next = quat_dcm(s1_mr_reg);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                for (int k = 0; k < 3; k++) begin
                    s3_p_next[i*9 + j*3 + k] = rmul(s2_cb_reg[i*3 + k], s2_cr_reg[j*3 + k]);
                end
                s4_c_next[i*3 + j] = sat_q(sx_rnd(s3_p_reg[i*9 + j*3])
                                         + sx_rnd(s3_p_reg[i*9 + j*3 + 1])
                                         + sx_rnd(s3_p_reg[i*9 + j*3 + 2]));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_mb_reg <= s1_mb_next;
            s1_mr_reg <= s1_mr_next;
            s2_cb_reg <= s2_cb_next;
            s2_cr_reg <= s2_cr_next;
            s3_p_reg  <= s3_p_next;
            s4_c_reg  <= s4_c_next;
        end
    end

    // stage 5: branch select, root argument, numerator combinations
    arg_t             tr, arg;
    branch_t          br_next;
    logic [RAD_W-1:0] rad_next;
    q_t               c00, c01, c02, c10, c11, c12, c20, c21, c22;
    logic [COMB_W-1:0] d12, d20, d01, s01, s02, s12;

    always_comb begin
        c00 = s4_c_reg[0]; c01 = s4_c_reg[1]; c02 = s4_c_reg[2];
        c10 = s4_c_reg[3]; c11 = s4_c_reg[4]; c12 = s4_c_reg[5];
        c20 = s4_c_reg[6]; c21 = s4_c_reg[7]; c22 = s4_c_reg[8];
        tr  = sx_arg(c00) + sx_arg(c11) + sx_arg(c22);
        d12 = {c12[Q_W-1], c12} - {c21[Q_W-1], c21};
        d20 = {c20[Q_W-1], c20} - {c02[Q_W-1], c02};
        d01 = {c01[Q_W-1], c01} - {c10[Q_W-1], c10};
        s01 = {c01[Q_W-1], c01} + {c10[Q_W-1], c10};
        s02 = {c02[Q_W-1], c02} + {c20[Q_W-1], c20};
        s12 = {c12[Q_W-1], c12} + {c21[Q_W-1], c21};
        if (tr > 0) begin
            br_next = BR_TRACE;
            arg     = ARG_ONE + tr;
        end else if (c00 > c11 && c00 > c22) begin
            br_next = BR_X;
            arg     = ARG_ONE + sx_arg(c00) - sx_arg(c11) - sx_arg(c22);
        end else if (c11 > c22) begin
            br_next = BR_Y;
            arg     = ARG_ONE + sx_arg(c11) - sx_arg(c00) - sx_arg(c22);
        end else begin
            br_next = BR_Z;
            arg     = ARG_ONE + sx_arg(c22) - sx_arg(c00) - sx_arg(c11);
        end
        if (arg[ARG_W-1]) begin
            rad_next = '0;
        end else begin
            rad_next = {{(RAD_W-ARG_W+1){1'b0}}, arg[ARG_W-2:0]} << (FRAC_BITS - 2);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_rem_reg[0]  <= rad_next;
            sq_root_reg[0] <= '0;
            sq_side_reg[0].br <= br_next;
            case (br_next)
                BR_TRACE: sq_side_reg[0].comb <= {d01, d20, d12};
                BR_X:     sq_side_reg[0].comb <= {s02, s01, d12};
                BR_Y:     sq_side_reg[0].comb <= {s12, s01, d20};
                default:  sq_side_reg[0].comb <= {s12, s02, d01};
            endcase
        end
    end

    // square root, one bit per stage
    for (genvar s = 0; s < SQ_N; s++) begin : g_sq
        localparam int SB = SQ_N - 1 - s;
        logic [SQT_W-1:0]  t;
        logic              ge;
        logic [RAD_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        always_comb begin
            t  = (SQT_W'(sq_root_reg[s]) << (SB + 1)) + (SQT_W'(1) << (2 * SB));
            ge = SQT_W'(sq_rem_reg[s]) >= t;
            rem_next  = ge ? sq_rem_reg[s] - t[RAD_W-1:0] : sq_rem_reg[s];
            root_next = ge ? sq_root_reg[s] | (ROOT_W'(1) << SB) : sq_root_reg[s];
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[s+1]  <= rem_next;
                sq_root_reg[s+1] <= root_next;
                sq_side_reg[s+1] <= sq_side_reg[s];
            end
        end
    end

    // divider setup: magnitudes, signs, overflow
    dv_side_t         dv0_side_next;
    logic [RAD_W-1:0] dv0_rem_next [3];
    logic [COMB_W-1:0] cmag;

    always_comb begin
        dv0_side_next.br  = sq_side_reg[SQ_N].br;
        dv0_side_next.piv = sq_root_reg[SQ_N];
        dv0_side_next.pz  = (sq_root_reg[SQ_N] == '0);
        cmag = '0;
        for (int k = 0; k < 3; k++) begin
            dv0_side_next.neg[k] = sq_side_reg[SQ_N].comb[k][COMB_W-1];
            cmag = dv0_side_next.neg[k] ? -sq_side_reg[SQ_N].comb[k]
                                        : sq_side_reg[SQ_N].comb[k];
            dv0_rem_next[k] = RAD_W'(cmag) << (FRAC_BITS - 2);
            dv0_side_next.ovf[k] = dv0_rem_next[k] >= {sq_root_reg[SQ_N], {DV_N{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_side_reg[0] <= dv0_side_next;
            for (int k = 0; k < 3; k++) begin
                dv_rem_reg[0][k] <= dv0_rem_next[k];
                dv_quo_reg[0][k] <= '0;
            end
        end
    end

    // three restoring dividers, one quotient bit per stage
    for (genvar s = 0; s < DV_N; s++) begin : g_dv
        localparam int DB = DV_N - 1 - s;
        logic [RAD_W-1:0] t;
        logic [RAD_W-1:0] rem_next [3];
        logic [DV_N-1:0]  quo_next [3];

        always_comb begin
            t = RAD_W'(dv_side_reg[s].piv) << DB;
            for (int k = 0; k < 3; k++) begin
                if (dv_rem_reg[s][k] >= t) begin
                    rem_next[k] = dv_rem_reg[s][k] - t;
                    quo_next[k] = dv_quo_reg[s][k] | (DV_N'(1) << DB);
                end else begin
                    rem_next[k] = dv_rem_reg[s][k];
                    quo_next[k] = dv_quo_reg[s][k];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_side_reg[s+1] <= dv_side_reg[s];
                for (int k = 0; k < 3; k++) begin
                    dv_rem_reg[s+1][k] <= rem_next[k];
                    dv_quo_reg[s+1][k] <= quo_next[k];
                end
            end
        end
    end

    // output: place parts, sign fix, saturate
    val_t            vpart [3];
    val_t            e     [4];
    logic [DV_N-1:0] mq;
    val_t            pv;

    always_comb begin
        mq = '0;
        for (int k = 0; k < 3; k++) begin
            if (dv_side_reg[DV_N].pz) begin
                mq = '0;
            end else if (dv_side_reg[DV_N].ovf[k]) begin
                mq = '1;
            end else begin
                mq = dv_quo_reg[DV_N][k];
            end
            vpart[k] = dv_side_reg[DV_N].neg[k] ? -val_t'({2'b00, mq}) : val_t'({2'b00, mq});
        end
        pv = val_t'({2'b00, dv_side_reg[DV_N].piv});
        case (dv_side_reg[DV_N].br)
            BR_TRACE: begin
                e[0] = pv;       e[1] = vpart[0]; e[2] = vpart[1]; e[3] = vpart[2];
            end
            BR_X: begin
                e[0] = vpart[0]; e[1] = pv;       e[2] = vpart[1]; e[3] = vpart[2];
            end
            BR_Y: begin
                e[0] = vpart[0]; e[1] = vpart[1]; e[2] = pv;       e[3] = vpart[2];
            end
            default: begin
                e[0] = vpart[0]; e[1] = vpart[1]; e[2] = vpart[2]; e[3] = pv;
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            if (e[0][VAL_W-1]) begin
                m_err_next[i] = sat_q({{(SUM_W-VAL_W){1'b0}}, -e[i]} |
                    {{(SUM_W-VAL_W){(-e[i]) < 0}}, {VAL_W{1'b0}}});
            end else begin
                m_err_next[i] = sat_q({{(SUM_W-VAL_W){e[i][VAL_W-1]}}, e[i]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_err_reg <= m_err_next;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            sq_vld_reg  <= '0;
            dv_vld_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            sq_vld_reg  <= {sq_vld_reg[SQ_N-1:0], s4_vld_reg};
            dv_vld_reg  <= {dv_vld_reg[DV_N-1:0], sq_vld_reg[SQ_N]};
            m_valid_reg <= dv_vld_reg[DV_N];
        end
    end

    a_err_q0_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_err_q0[Q_W-1])
        else $error("err_q0 negative");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while pipeline stalled");

    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_vld_reg[SQ_N] |-> !sq_root_reg[SQ_N][ROOT_W-1])
        else $error("square root out of range");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && dv_vld_reg[DV_N]) |=> m_valid)
        else $error("result lost at output stage");

endmodule
`default_nettype wire
